// ===== hw/rtl/event_queue_dispatcher_macros.svh =====
// Assertion helpers shared by the RTL of the event queue dispatcher.
// Each macro expands to one labeled concurrent assertion on clk_i.
`ifndef EVENT_QUEUE_DISPATCHER_MACROS_SVH
`define EVENT_QUEUE_DISPATCHER_MACROS_SVH

// The property is ignored while rst_ni is low.
`define EQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The property must also hold while the block is in reset.
`define EQD_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/eqd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_pkg
// Sizes, codes, request structs and helper functions for the event queue
// dispatcher.
// ----------------------------------------------------------------------------
package eqd_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int EVENT_KINDS  = 16;
  localparam int MAX_SUBS     = 8;
  localparam int PAYLOAD_BITS = 16;

  // Fixed field widths of the request and response channels.
  localparam int FUNC_W   = 2;
  localparam int EV_W     = 4;
  localparam int SUB_W    = 8;
  localparam int PL_W     = 16;
  localparam int STATUS_W = 3;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int EK_W   = (EVENT_KINDS > 1) ? $clog2(EVENT_KINDS) : 1;
  localparam int CNT_W  = $clog2(MAX_SUBS + 1);
  localparam int TAB_DEPTH = EVENT_KINDS * MAX_SUBS;
  localparam int TAB_W  = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

  localparam logic [FUNC_W-1:0] FN_REGISTER   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_UNREGISTER = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POST       = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DISPATCH   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QFULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LFULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOSUB    = 3'd5;

  // Control toward the subscriber store.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic             cnt_wr_en;
    logic [EK_W-1:0]  ev;
    logic [CNT_W-1:0] rd_idx;
    logic [CNT_W-1:0] wr_idx;
    logic [SUB_W-1:0] wr_data;
    logic [CNT_W-1:0] cnt_val;
  } sub_req_t;

  // Control toward the event ring.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic [EV_W-1:0]         ev;
    logic [PAYLOAD_BITS-1:0] pl;
  } ring_req_t;

  function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic ev_in_range(input logic [EV_W-1:0] ev);
    logic r;
    r = (32'(ev) < 32'(EVENT_KINDS));
    return r;
  endfunction

  function automatic logic [TAB_W-1:0] tab_addr(input logic [EK_W-1:0] ek,
                                                input logic [CNT_W-1:0] idx);
    logic [TAB_W-1:0] r;
    r = TAB_W'(TAB_W'(ek) * TAB_W'(MAX_SUBS)) + TAB_W'(idx);
    return r;
  endfunction

endpackage

// ===== hw/rtl/eqd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_req_if
// Request channel: operation code, event, subscriber and payload.
// ----------------------------------------------------------------------------
interface eqd_req_if;
  logic                           valid;
  logic                           ready;
  logic [eqd_pkg::FUNC_W-1:0]     func;
  logic [eqd_pkg::EV_W-1:0]       event_num;
  logic [eqd_pkg::SUB_W-1:0]      subscriber;
  logic [eqd_pkg::PL_W-1:0]       payload;

  modport source (output valid, func, event_num, subscriber, payload, input ready);
  modport sink   (input valid, func, event_num, subscriber, payload, output ready);
endinterface

// ===== hw/rtl/eqd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_rsp_if
// Response channel: status, notified subscriber, fired event and last flag.
// ----------------------------------------------------------------------------
interface eqd_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [eqd_pkg::STATUS_W-1:0]   status;
  logic [eqd_pkg::SUB_W-1:0]      target;
  logic [eqd_pkg::EV_W-1:0]       fired_event;
  logic [eqd_pkg::PL_W-1:0]       fired_payload;
  logic                           last;

  modport source (output valid, status, target, fired_event, fired_payload, last,
                  input ready);
  modport sink   (input valid, status, target, fired_event, fired_payload, last,
                  output ready);
endinterface

// ===== hw/rtl/eqd_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_ring
// Ring queue of posted events with one slot kept free, and a registered read
// of the slot that a pop moves onto.
// ----------------------------------------------------------------------------
module eqd_ring (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  eqd_pkg::ring_req_t                req_i,
  output logic                              full_o,
  output logic                              empty_o,
  output logic [eqd_pkg::EV_W-1:0]          rd_ev_o,
  output logic [eqd_pkg::PAYLOAD_BITS-1:0]  rd_pl_o
);

  logic [eqd_pkg::EV_W-1:0]         ev_mem [eqd_pkg::QUEUE_DEPTH];
  logic [eqd_pkg::PAYLOAD_BITS-1:0] pl_mem [eqd_pkg::QUEUE_DEPTH];

  logic [eqd_pkg::QPTR_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [eqd_pkg::QPTR_W-1:0] rp_nx, wp_nx;
  logic [eqd_pkg::EV_W-1:0]         rd_ev_q;
  logic [eqd_pkg::PAYLOAD_BITS-1:0] rd_pl_q;

  assign rp_nx   = eqd_pkg::qptr_next(rp_q);
  assign wp_nx   = eqd_pkg::qptr_next(wp_q);
  assign full_o  = (wp_nx == rp_q);
  assign empty_o = (rp_q == wp_q);
  assign rd_ev_o = rd_ev_q;
  assign rd_pl_o = rd_pl_q;

  always_comb begin
    rp_d = rp_q;
    wp_d = wp_q;
    if (req_i.push) begin
      wp_d = wp_nx;
    end
    if (req_i.pop) begin
      rp_d = rp_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
      wp_q <= '0;
    end else begin
      rp_q <= rp_d;
      wp_q <= wp_d;
    end
  end

  // The new write pointer names the slot that receives the event.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      ev_mem[wp_nx] <= req_i.ev;
      pl_mem[wp_nx] <= req_i.pl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.pop) begin
      rd_ev_q <= ev_mem[rp_nx];
      rd_pl_q <= pl_mem[rp_nx];
    end
  end

endmodule

// ===== hw/rtl/eqd_sub_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqd_sub_store
// Subscriber lists: a table memory with one write and one registered read
// port, and a per-event list length held in flops.
// ----------------------------------------------------------------------------
module eqd_sub_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eqd_pkg::sub_req_t             req_i,
  output logic [eqd_pkg::SUB_W-1:0]     rd_data_o,
  output logic [eqd_pkg::CNT_W-1:0]     cnt_o
);

  logic [eqd_pkg::SUB_W-1:0] tab_mem [eqd_pkg::TAB_DEPTH];
  logic [eqd_pkg::SUB_W-1:0] rd_data_q;
  logic [eqd_pkg::CNT_W-1:0] cnt_q [eqd_pkg::EVENT_KINDS];

  assign rd_data_o = rd_data_q;
  assign cnt_o     = cnt_q[req_i.ev];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      tab_mem[eqd_pkg::tab_addr(req_i.ev, req_i.wr_idx)] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= tab_mem[eqd_pkg::tab_addr(req_i.ev, req_i.rd_idx)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < eqd_pkg::EVENT_KINDS; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (req_i.cnt_wr_en) begin
      cnt_q[req_i.ev] <= req_i.cnt_val;
    end
  end

endmodule

// ===== hw/rtl/event_queue_dispatcher.sv =====
`timescale 1ns / 1ps
`include "event_queue_dispatcher_macros.svh"
// ----------------------------------------------------------------------------
// event_queue_dispatcher
// Publish-subscribe engine: per-event subscriber lists, a ring of posted
// events, and a sequencer that walks one list entry at a time.
//
//   Channel  Dir  Carries
//   req_i    in   func, event_num, subscriber, payload
//   rsp_o    out  status, target, fired_event, fired_payload, last
//
// Register and post pass S_EXEC and S_RESP. Unregister passes S_EXEC, then
// S_U_RD/S_U_CMP per entry searched, S_S_RD/S_S_WR per entry shifted, S_RESP.
// Dispatch: S_EXEC, S_D_LD, S_D_RD/S_D_OUT per subscriber; S_RESP if there is none.
// Reset clears the list lengths and ring pointers; no clearing pass is needed.
// A stalled response holds the sequencer; no new request is taken until the
// final response of the current one is in the output register.
// ----------------------------------------------------------------------------
module event_queue_dispatcher (
  input  logic      clk_i,
  input  logic      rst_ni,
  eqd_req_if.sink   req_i,
  eqd_rsp_if.source rsp_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_U_RD  = 4'd2;
  localparam logic [3:0] S_U_CMP = 4'd3;
  localparam logic [3:0] S_S_RD  = 4'd4;
  localparam logic [3:0] S_S_WR  = 4'd5;
  localparam logic [3:0] S_D_LD  = 4'd6;
  localparam logic [3:0] S_D_RD  = 4'd7;
  localparam logic [3:0] S_D_OUT = 4'd8;
  localparam logic [3:0] S_RESP  = 4'd9;

  logic [3:0] state_q, state_d;

  logic [eqd_pkg::FUNC_W-1:0]       func_q, func_d;
  logic [eqd_pkg::EV_W-1:0]         ev_q, ev_d;
  logic [eqd_pkg::SUB_W-1:0]        sub_q, sub_d;
  logic [eqd_pkg::PAYLOAD_BITS-1:0] pl_q, pl_d;
  logic [eqd_pkg::CNT_W-1:0]        idx_q, idx_d;
  logic [eqd_pkg::CNT_W-1:0]        n_q, n_d;
  logic [eqd_pkg::STATUS_W-1:0]     status_q, status_d;
  logic                             show_q, show_d;
  logic [eqd_pkg::EV_W-1:0]         fev_q, fev_d;
  logic [eqd_pkg::PAYLOAD_BITS-1:0] fpl_q, fpl_d;

  logic                             rsp_valid_q, rsp_valid_d;
  logic [eqd_pkg::STATUS_W-1:0]     rsp_status_q;
  logic [eqd_pkg::SUB_W-1:0]        rsp_target_q;
  logic [eqd_pkg::EV_W-1:0]         rsp_event_q;
  logic [eqd_pkg::PL_W-1:0]         rsp_payload_q;
  logic                             rsp_last_q;

  logic                             emit, can_emit;
  logic [eqd_pkg::STATUS_W-1:0]     e_status;
  logic [eqd_pkg::SUB_W-1:0]        e_target;
  logic [eqd_pkg::EV_W-1:0]         e_ev;
  logic [eqd_pkg::PL_W-1:0]         e_pl;
  logic                             e_last;

  eqd_pkg::sub_req_t                sreq;
  eqd_pkg::ring_req_t               rreq;
  logic [eqd_pkg::SUB_W-1:0]        tab_rd;
  logic [eqd_pkg::CNT_W-1:0]        cnt;
  logic                             ring_full, ring_empty;
  logic [eqd_pkg::EV_W-1:0]         ring_ev;
  logic [eqd_pkg::PAYLOAD_BITS-1:0] ring_pl;

  logic                             req_fire;
  logic                             rsp_nosub;

  eqd_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rreq),
    .full_o  (ring_full),
    .empty_o (ring_empty),
    .rd_ev_o (ring_ev),
    .rd_pl_o (ring_pl)
  );

  eqd_sub_store u_sub_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sreq),
    .rd_data_o (tab_rd),
    .cnt_o     (cnt)
  );

  assign req_i.ready         = (state_q == S_IDLE);
  assign can_emit            = !rsp_valid_q || rsp_o.ready;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.target        = rsp_target_q;
  assign rsp_o.fired_event   = rsp_event_q;
  assign rsp_o.fired_payload = rsp_payload_q;
  assign rsp_o.last          = rsp_last_q;

  assign req_fire  = req_i.valid && req_i.ready;
  assign rsp_nosub = rsp_o.valid && (rsp_o.status == eqd_pkg::ST_NOSUB);

  always_comb begin
    state_d  = state_q;
    func_d   = func_q;
    ev_d     = ev_q;
    sub_d    = sub_q;
    pl_d     = pl_q;
    idx_d    = idx_q;
    n_d      = n_q;
    status_d = status_q;
    show_d   = show_q;
    fev_d    = fev_q;
    fpl_d    = fpl_q;

    emit     = 1'b0;
    e_status = eqd_pkg::ST_OK;
    e_target = '0;
    e_ev     = '0;
    e_pl     = '0;
    e_last   = 1'b1;

    sreq         = '0;
    sreq.rd_idx  = idx_q;
    sreq.wr_idx  = idx_q;
    sreq.wr_data = sub_q;
    // The list length and table are addressed by the popped event while
    // dispatching and by the request's event otherwise.
    if (state_q == S_D_LD) begin
      sreq.ev = eqd_pkg::EK_W'(ring_ev);
    end else if (state_q == S_D_RD || state_q == S_D_OUT) begin
      sreq.ev = eqd_pkg::EK_W'(fev_q);
    end else begin
      sreq.ev = eqd_pkg::EK_W'(ev_q);
    end

    rreq    = '0;
    rreq.ev = ev_q;
    rreq.pl = pl_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d  = req_i.func;
          ev_d    = req_i.event_num;
          sub_d   = req_i.subscriber;
          pl_d    = eqd_pkg::PAYLOAD_BITS'(req_i.payload);
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        show_d  = 1'b0;
        state_d = S_RESP;
        unique case (func_q)
          eqd_pkg::FN_REGISTER: begin
            if (!eqd_pkg::ev_in_range(ev_q) ||
                cnt >= eqd_pkg::CNT_W'(eqd_pkg::MAX_SUBS)) begin
              status_d = eqd_pkg::ST_LFULL;
            end else begin
              sreq.wr_en     = 1'b1;
              sreq.wr_idx    = cnt;
              sreq.cnt_wr_en = 1'b1;
              sreq.cnt_val   = cnt + 1'b1;
              status_d       = eqd_pkg::ST_OK;
            end
          end
          eqd_pkg::FN_UNREGISTER: begin
            if (!eqd_pkg::ev_in_range(ev_q)) begin
              status_d = eqd_pkg::ST_NOTFOUND;
            end else begin
              n_d     = cnt;
              idx_d   = '0;
              state_d = S_U_RD;
            end
          end
          eqd_pkg::FN_POST: begin
            if (ring_full) begin
              status_d = eqd_pkg::ST_QFULL;
            end else begin
              rreq.push = 1'b1;
              status_d  = eqd_pkg::ST_OK;
            end
          end
          eqd_pkg::FN_DISPATCH: begin
            if (ring_empty) begin
              status_d = eqd_pkg::ST_EMPTY;
            end else begin
              rreq.pop = 1'b1;
              state_d  = S_D_LD;
            end
          end
          default: begin
            status_d = eqd_pkg::ST_OK;
          end
        endcase
      end
      S_U_RD: begin
        if (idx_q >= n_q) begin
          status_d = eqd_pkg::ST_NOTFOUND;
          state_d  = S_RESP;
        end else begin
          sreq.rd_en = 1'b1;
          state_d    = S_U_CMP;
        end
      end
      S_U_CMP: begin
        if (tab_rd == sub_q) begin
          state_d = S_S_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_U_RD;
        end
      end
      S_S_RD: begin
        // Close the gap left by the removed entry one slot at a time.
        if (idx_q + 1'b1 < n_q) begin
          sreq.rd_en  = 1'b1;
          sreq.rd_idx = idx_q + 1'b1;
          state_d     = S_S_WR;
        end else begin
          sreq.cnt_wr_en = 1'b1;
          sreq.cnt_val   = n_q - 1'b1;
          status_d       = eqd_pkg::ST_OK;
          state_d        = S_RESP;
        end
      end
      S_S_WR: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_data = tab_rd;
        idx_d        = idx_q + 1'b1;
        state_d      = S_S_RD;
      end
      S_D_LD: begin
        fev_d = ring_ev;
        fpl_d = ring_pl;
        idx_d = '0;
        if (!eqd_pkg::ev_in_range(ring_ev) || cnt == '0) begin
          show_d   = 1'b1;
          status_d = eqd_pkg::ST_NOSUB;
          state_d  = S_RESP;
        end else begin
          n_d     = cnt;
          state_d = S_D_RD;
        end
      end
      S_D_RD: begin
        sreq.rd_en = 1'b1;
        state_d    = S_D_OUT;
      end
      S_D_OUT: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_status = eqd_pkg::ST_OK;
          e_target = tab_rd;
          e_ev     = fev_q;
          e_pl     = eqd_pkg::PL_W'(fpl_q);
          e_last   = (idx_q + 1'b1 == n_q);
          idx_d    = idx_q + 1'b1;
          state_d  = e_last ? S_IDLE : S_D_RD;
        end
      end
      S_RESP: begin
        if (can_emit) begin
          emit     = 1'b1;
          e_status = status_q;
          e_ev     = show_q ? fev_q : '0;
          e_pl     = show_q ? eqd_pkg::PL_W'(fpl_q) : '0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_valid_d = emit || (rsp_valid_q && !rsp_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      show_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      show_q      <= show_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    ev_q     <= ev_d;
    sub_q    <= sub_d;
    pl_q     <= pl_d;
    status_q <= status_d;
    fev_q    <= fev_d;
    fpl_q    <= fpl_d;
    if (emit) begin
      rsp_status_q  <= e_status;
      rsp_target_q  <= e_target;
      rsp_event_q   <= e_ev;
      rsp_payload_q <= e_pl;
      rsp_last_q    <= e_last;
    end
  end

  `EQD_ASSERT(a_busy_after_request, req_fire |=> !req_i.ready, "ready high after a request")
  `EQD_ASSERT(a_walk_in_list, (state_q == S_D_OUT) |-> (idx_q < n_q), "walk past list end")
  `EQD_ASSERT(a_nosub_single, rsp_nosub |-> (rsp_o.last && rsp_o.target == '0), "bad no-sub reply")
  `EQD_ASSERT_NR(a_fanout_busy, rsp_o.valid && !rsp_o.last |-> !req_i.ready, "taken in fan-out")

endmodule

// ===== sim/event_queue_dispatcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_queue_dispatcher_tb
// Drives register, unregister, post and dispatch requests into the event
// dispatcher with random gaps, and checks every response against a
// cycle-free model of the subscriber lists and the event ring.
// ----------------------------------------------------------------------------
module event_queue_dispatcher_tb;

  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_AT       = 40;    // response count that starts the long hold
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;    // longer than a worst-case unregister
  localparam int STALL_LIMIT   = 4000;  // cycles with no transfer on either channel

  typedef struct packed {
    logic [eqd_pkg::FUNC_W-1:0] func;
    logic [eqd_pkg::EV_W-1:0]   ev;
    logic [eqd_pkg::SUB_W-1:0]  sub;
    logic [eqd_pkg::PL_W-1:0]   pl;
  } request_t;

  typedef struct packed {
    logic [eqd_pkg::STATUS_W-1:0] status;
    logic [eqd_pkg::SUB_W-1:0]    target;
    logic [eqd_pkg::EV_W-1:0]     ev;
    logic [eqd_pkg::PL_W-1:0]     pl;
    logic                         last;
  } notice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  eqd_req_if req_if ();
  eqd_rsp_if rsp_if ();

  event_queue_dispatcher uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the dispatcher state; the counters start at zero.
  logic [eqd_pkg::SUB_W-1:0] sub_list     [eqd_pkg::EVENT_KINDS][eqd_pkg::MAX_SUBS];
  int unsigned               list_len     [eqd_pkg::EVENT_KINDS];
  logic [eqd_pkg::EV_W-1:0]  ring_event   [eqd_pkg::QUEUE_DEPTH];
  logic [eqd_pkg::PL_W-1:0]  ring_payload [eqd_pkg::QUEUE_DEPTH];
  int unsigned               ring_rd;
  int unsigned               ring_wr;

  request_t pending_requests[$];
  notice_t  due_notices[$];

  int total_requests = 0;
  int sent_requests  = 0;
  int seen_notices   = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  function automatic void add_notice(input logic [eqd_pkg::STATUS_W-1:0] status,
                                     input logic [eqd_pkg::SUB_W-1:0] target,
                                     input logic [eqd_pkg::EV_W-1:0] ev,
                                     input logic [eqd_pkg::PL_W-1:0] pl,
                                     input logic last);
    notice_t n;
    n.status = status;
    n.target = target;
    n.ev     = ev;
    n.pl     = pl;
    n.last   = last;
    due_notices.push_back(n);
  endfunction

  // Applies one accepted request to the shadow state and queues the responses.
  function automatic void track_request(input request_t r);
    int unsigned              ek;
    int unsigned              n;
    int unsigned              i;
    int unsigned              k;
    int unsigned              nxt;
    logic                     found;
    logic [eqd_pkg::EV_W-1:0] e;
    logic [eqd_pkg::PL_W-1:0] p;
    ek = int'(r.ev);
    case (r.func)
      eqd_pkg::FN_REGISTER: begin
        if (ek >= eqd_pkg::EVENT_KINDS || list_len[ek] >= eqd_pkg::MAX_SUBS) begin
          add_notice(eqd_pkg::ST_LFULL, '0, '0, '0, 1'b1);
        end else begin
          sub_list[ek][list_len[ek]] = r.sub;
          list_len[ek]++;
          add_notice(eqd_pkg::ST_OK, '0, '0, '0, 1'b1);
        end
      end
      eqd_pkg::FN_UNREGISTER: begin
        found = 1'b0;
        if (ek < eqd_pkg::EVENT_KINDS) begin
          n = list_len[ek];
          for (i = 0; i < n && !found; i++) begin
            if (sub_list[ek][i] == r.sub) begin
              // Close the gap so the remaining entries keep their order.
              for (k = i; k + 1 < n; k++) sub_list[ek][k] = sub_list[ek][k + 1];
              list_len[ek] = n - 1;
              found = 1'b1;
            end
          end
        end
        add_notice(found ? eqd_pkg::ST_OK : eqd_pkg::ST_NOTFOUND, '0, '0, '0, 1'b1);
      end
      eqd_pkg::FN_POST: begin
        nxt = (ring_wr + 1) % eqd_pkg::QUEUE_DEPTH;
        if (nxt == ring_rd) begin
          add_notice(eqd_pkg::ST_QFULL, '0, '0, '0, 1'b1);
        end else begin
          ring_wr = nxt;
          ring_event[nxt]   = r.ev;
          ring_payload[nxt] = eqd_pkg::PL_W'(r.pl &
              eqd_pkg::PL_W'((33'd1 << eqd_pkg::PAYLOAD_BITS) - 1));
          add_notice(eqd_pkg::ST_OK, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        if (ring_rd == ring_wr) begin
          add_notice(eqd_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          ring_rd = (ring_rd + 1) % eqd_pkg::QUEUE_DEPTH;
          e = ring_event[ring_rd];
          p = ring_payload[ring_rd];
          n = (int'(e) < eqd_pkg::EVENT_KINDS) ? list_len[int'(e)] : 0;
          if (n > eqd_pkg::MAX_SUBS) n = eqd_pkg::MAX_SUBS;
          if (n == 0) begin
            add_notice(eqd_pkg::ST_NOSUB, '0, e, p, 1'b1);
          end else begin
            for (i = 0; i < n; i++)
              add_notice(eqd_pkg::ST_OK, sub_list[int'(e)][i], e, p, i + 1 == n);
          end
        end
      end
    endcase
  endfunction

  function automatic void add_request(input logic [eqd_pkg::FUNC_W-1:0] func,
                                      input logic [eqd_pkg::EV_W-1:0] ev,
                                      input logic [eqd_pkg::SUB_W-1:0] sub,
                                      input logic [eqd_pkg::PL_W-1:0] pl);
    request_t r;
    r.func = func;
    r.ev   = ev;
    r.sub  = sub;
    r.pl   = pl;
    pending_requests.push_back(r);
  endfunction

  // Random requests with the operation mix given by the weights. Events and
  // subscribers mostly come from small pools so lists fill up and unregister
  // finds matches, duplicates included.
  function automatic void add_random(input int w_reg, input int w_unreg,
                                     input int w_post, input int w_disp,
                                     input int count);
    int                         pick;
    logic [eqd_pkg::FUNC_W-1:0] func;
    logic [eqd_pkg::EV_W-1:0]   ev;
    logic [eqd_pkg::SUB_W-1:0]  sub;
    logic [eqd_pkg::PL_W-1:0]   pl;
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(0, w_reg + w_unreg + w_post + w_disp - 1);
      if (pick < w_reg) func = eqd_pkg::FN_REGISTER;
      else if (pick < w_reg + w_unreg) func = eqd_pkg::FN_UNREGISTER;
      else if (pick < w_reg + w_unreg + w_post) func = eqd_pkg::FN_POST;
      else func = eqd_pkg::FN_DISPATCH;
      ev  = ($urandom_range(0, 3) != 0) ? eqd_pkg::EV_W'($urandom_range(0, 3))
                                        : eqd_pkg::EV_W'($urandom);
      sub = ($urandom_range(0, 4) != 0) ? eqd_pkg::SUB_W'($urandom_range(0, 7))
                                        : eqd_pkg::SUB_W'($urandom);
      case ($urandom_range(0, 11))
        0:       pl = '0;
        1:       pl = '1;
        default: pl = eqd_pkg::PL_W'($urandom);
      endcase
      add_request(func, ev, sub, pl);
    end
  endfunction

  // Request driver: one request held on the bus until it is taken.
  int req_gap    = 0;
  int req_steady = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid      <= 1'b0;
      req_if.func       <= '0;
      req_if.event_num  <= '0;
      req_if.subscriber <= '0;
      req_if.payload    <= '0;
      req_gap           <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        track_request('{req_if.func, req_if.event_num, req_if.subscriber, req_if.payload});
        sent_requests++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_if.valid <= 1'b0;
          req_gap      <= req_gap - 1;
        end else if (pending_requests.size() != 0) begin
          request_t r;
          r = pending_requests.pop_front();
          req_if.valid      <= 1'b1;
          req_if.func       <= r.func;
          req_if.event_num  <= r.ev;
          req_if.subscriber <= r.sub;
          req_if.payload    <= r.pl;
          if (req_steady > 0) begin
            req_steady--;
            req_gap <= 0;
          end else begin
            if ($urandom_range(0, 24) == 0) req_steady = 20;
            req_gap <= $urandom_range(0, 4);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: random back-pressure, one long hold, and the check.
  int rsp_wait   = 0;
  int rsp_steady = 0;

  always @(posedge clk or negedge rst_n) begin
    int      w;
    notice_t got;
    notice_t want;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rsp_wait     <= 0;
    end else begin
      w = rsp_wait;
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = rsp_if.status;
        got.target = rsp_if.target;
        got.ev     = rsp_if.fired_event;
        got.pl     = rsp_if.fired_payload;
        got.last   = rsp_if.last;
        seen_notices++;
        if (due_notices.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("response %0d unexpected: st/tgt/ev/pl/last %0d/%0h/%0d/%0h/%0b",
                     seen_notices, got.status, got.target, got.ev, got.pl, got.last);
        end else begin
          want = due_notices.pop_front();
          if (got.status !== want.status || got.target !== want.target ||
              got.ev !== want.ev || got.pl !== want.pl || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("response %0d st/tgt/ev/pl/last: %s %0d/%0h/%0d/%0h/%0b, %s %0d/%0h/%0d/%0h/%0b",
                       seen_notices,
                       "expected", want.status, want.target, want.ev, want.pl, want.last,
                       "got", got.status, got.target, got.ev, got.pl, got.last);
          end
        end
        if (seen_notices == HOLD_AT) begin
          w = HOLD_CYCLES;
        end else if (rsp_steady > 0) begin
          rsp_steady--;
          w = 0;
        end else begin
          if ($urandom_range(0, 24) == 0) rsp_steady = 20;
          w = $urandom_range(0, 4);
        end
      end else if (w > 0) begin
        w--;
      end
      rsp_wait     <= w;
      rsp_if.ready <= (w == 0);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("event_queue_dispatcher: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Directed opening: empty queue, missing entry, extreme IDs and payloads,
    // a full list with a duplicate, an event nobody listens to.
    add_request(eqd_pkg::FN_DISPATCH,   '0, '0, '0);
    add_request(eqd_pkg::FN_UNREGISTER, '0, '0, '0);
    add_request(eqd_pkg::FN_REGISTER,   '0, '0, '0);
    add_request(eqd_pkg::FN_REGISTER,   '1, '1, '0);
    add_request(eqd_pkg::FN_POST,       '1, '0, '1);
    add_request(eqd_pkg::FN_POST,       '0, '1, '0);
    add_request(eqd_pkg::FN_POST,       eqd_pkg::EV_W'(7), '0, eqd_pkg::PL_W'(16'hA5A5));
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(1), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(2), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(3), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(2), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(4), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(5), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(6), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(7), '0);
    add_request(eqd_pkg::FN_REGISTER,   eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(9), '0);
    add_request(eqd_pkg::FN_POST,       eqd_pkg::EV_W'(3), '0, eqd_pkg::PL_W'(16'h1234));
    add_request(eqd_pkg::FN_DISPATCH,   '0, '0, '0);
    add_request(eqd_pkg::FN_DISPATCH,   '0, '0, '0);
    add_request(eqd_pkg::FN_DISPATCH,   '0, '0, '0);
    add_request(eqd_pkg::FN_UNREGISTER, eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(2), '0);
    add_request(eqd_pkg::FN_UNREGISTER, eqd_pkg::EV_W'(3), eqd_pkg::SUB_W'(8), '0);
    add_request(eqd_pkg::FN_DISPATCH,   '0, '0, '0);
    add_request(eqd_pkg::FN_UNREGISTER, '1, '1, '0);
    add_request(eqd_pkg::FN_DISPATCH,   '0, '0, '0);

    // Random phases: a mixed start, list building, a flood that overruns the
    // ring, a drain past empty, list trimming, and a mixed finish.
    add_random(30, 20, 25, 25, 60);
    add_random(60, 10, 15, 15, 40);
    add_random(0, 0, 1, 0, 75);
    add_random(10, 5, 5, 80, 80);
    add_random(20, 60, 10, 10, 30);
    add_random(30, 20, 25, 25, 35);
    total_requests = pending_requests.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_requests < total_requests || due_notices.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("event_queue_dispatcher: match");
    end else begin
      $display("event_queue_dispatcher: mismatch");
    end
    $finish;
  end

endmodule
